[hw/rtl/single_wire_humidity_sensor_receiver_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the single-wire humidity sensor receiver
// Shared shorthand for the concurrent checks. Every user has clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_RECEIVER_MACROS_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SHWR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SHWR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/shwr_pkg.sv]
// ----------------------------------------------------------------------------
// shwr_pkg
// Types, codes and helper functions shared by the sensor receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package shwr_pkg;

  // Field and register widths
  localparam int TIMEOUT_W     = 23;
  localparam int STATUS_W      = 2;
  localparam int VALUE_W       = 17;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 23;
  localparam int FRAME_BITS    = 40;
  localparam int BIT_IDX_W     = 6;
  localparam int QUEUE_DEPTH   = 4;
  localparam int COUNTER_WIDTH_DEF = 24;

  // Register reset values
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 23'd16000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_TEMP = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRE_TO   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BIT_TO   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CSUM_ERR = 2'd3;

  // Event kinds passed from the line timer to the result stage
  localparam logic [1:0] EV_PRE_TO = 2'd1;
  localparam logic [1:0] EV_BIT_TO = 2'd2;
  localparam logic [1:0] EV_FRAME  = 2'd3;

  typedef struct packed {
    logic [1:0]            kind;
    logic [FRAME_BITS-1:0] frame;
  } evt_t;

  // Byte-sum check: the low byte of the sum of bytes 0..3 equals byte 4
  function automatic logic csum_ok(input logic [FRAME_BITS-1:0] frame);
    logic [7:0] sum;
    sum = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
    return sum == frame[7:0];
  endfunction

  // Selected quantity in tenths from the five frame bytes
  function automatic logic signed [VALUE_W-1:0] dht_value(
    input logic [FRAME_BITS-1:0] bytes,
    input logic                  mode,
    input logic                  temp_sel
  );
    logic [7:0]         b0;
    logic [7:0]         b1;
    logic [7:0]         b2;
    logic [7:0]         b3;
    logic [7:0]         sel;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] res;
    b0  = bytes[39:32];
    b1  = bytes[31:24];
    b2  = bytes[23:16];
    b3  = bytes[15:8];
    sel = temp_sel ? b2 : b0;
    mag = VALUE_W'({b2[6:0], b3});
    if (!mode) begin
      // whole units times ten as x*8 + x*2
      res = VALUE_W'({sel, 3'b000}) + VALUE_W'({sel, 1'b0});
    end else if (!temp_sel) begin
      res = VALUE_W'({b0, b1});
    end else begin
      res = b2[7] ? (~mag + VALUE_W'(1)) : mag;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/shwr_front.sv]
// ----------------------------------------------------------------------------
// shwr_front
// Line timer: measures preamble and bit runs per sample, emits read events.
// ----------------------------------------------------------------------------
`default_nettype none

module shwr_front #(
  parameter int COUNTER_WIDTH = shwr_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           accept,
  input  wire logic                           operation,
  input  wire logic                           line_level,
  input  wire logic [shwr_pkg::TIMEOUT_W-1:0] timeout_ticks,
  output logic                                ev_push,
  output shwr_pkg::evt_t                      ev
);

  `include "single_wire_humidity_sensor_receiver_macros.svh"

  localparam int CMP_W = (COUNTER_WIDTH > shwr_pkg::TIMEOUT_W) ?
                         COUNTER_WIDTH : shwr_pkg::TIMEOUT_W;
  localparam int FB    = shwr_pkg::FRAME_BITS;
  localparam int BW    = shwr_pkg::BIT_IDX_W;

  // Read phases
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_PRE_LOW   = 3'd1;
  localparam logic [2:0] PH_PRE_HIGH  = 3'd2;
  localparam logic [2:0] PH_DATA_LOW  = 3'd3;
  localparam logic [2:0] PH_DATA_HIGH = 3'd4;

  localparam logic [COUNTER_WIDTH-1:0] RUN_ONE = COUNTER_WIDTH'(1);

  logic [2:0]               phase_r,     phase_nxt;
  logic [COUNTER_WIDTH-1:0] run_r,       run_nxt;
  logic [COUNTER_WIDTH-1:0] low_run_r,   low_run_nxt;
  logic [BW-1:0]            bit_idx_r,   bit_idx_nxt;
  logic [FB-1:0]            frame_r,     frame_nxt;
  logic [COUNTER_WIDTH-1:0] run_up;
  logic                     chk_bit;
  logic                     over;

  // Saturating run counter increment
  assign run_up = (&run_r) ? run_r : run_r + RUN_ONE;

  // Next-state and event logic
  always_comb begin
    phase_nxt   = phase_r;
    run_nxt     = run_r;
    low_run_nxt = low_run_r;
    bit_idx_nxt = bit_idx_r;
    frame_nxt   = frame_r;
    ev_push     = 1'b0;
    ev.kind     = shwr_pkg::EV_BIT_TO;
    chk_bit     = 1'b0;
    over        = 1'b0;
    if (accept) begin
      if (operation) begin
        phase_nxt   = PH_PRE_LOW;
        run_nxt     = '0;
        low_run_nxt = '0;
        bit_idx_nxt = '0;
        frame_nxt   = '0;
      end else begin
        unique case (phase_r)
          PH_PRE_LOW: begin
            if (line_level) begin
              phase_nxt = PH_PRE_HIGH;
              run_nxt   = RUN_ONE;
            end else begin
              run_nxt = run_up;
            end
            over = CMP_W'(run_nxt) > CMP_W'(timeout_ticks);
            if (over) begin
              ev_push   = 1'b1;
              ev.kind   = shwr_pkg::EV_PRE_TO;
              phase_nxt = PH_IDLE;
            end
          end
          PH_PRE_HIGH: begin
            if (line_level) begin
              run_nxt = run_up;
              over    = CMP_W'(run_nxt) > CMP_W'(timeout_ticks);
              if (over) begin
                ev_push   = 1'b1;
                ev.kind   = shwr_pkg::EV_PRE_TO;
                phase_nxt = PH_IDLE;
              end
            end else begin
              phase_nxt = PH_DATA_LOW;
              run_nxt   = RUN_ONE;
              chk_bit   = 1'b1;
            end
          end
          PH_DATA_LOW: begin
            if (line_level) begin
              low_run_nxt = run_r;
              phase_nxt   = PH_DATA_HIGH;
              run_nxt     = RUN_ONE;
            end else begin
              run_nxt = run_up;
            end
            chk_bit = 1'b1;
          end
          PH_DATA_HIGH: begin
            if (line_level) begin
              run_nxt = run_up;
              chk_bit = 1'b1;
            end else begin
              // bit is 1 when the high run is at least the low run
              frame_nxt   = {frame_r[FB-2:0], (run_r >= low_run_r)};
              bit_idx_nxt = bit_idx_r + BW'(1);
              if (bit_idx_nxt >= BW'(FB)) begin
                ev_push   = 1'b1;
                ev.kind   = shwr_pkg::EV_FRAME;
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_DATA_LOW;
                run_nxt   = RUN_ONE;
                chk_bit   = 1'b1;
              end
            end
          end
          default: begin
            // idle: samples are ignored
          end
        endcase
        // any over-long run inside the data part aborts the read
        if (chk_bit && (CMP_W'(run_nxt) > CMP_W'(timeout_ticks))) begin
          ev_push   = 1'b1;
          ev.kind   = shwr_pkg::EV_BIT_TO;
          phase_nxt = PH_IDLE;
        end
      end
    end
    ev.frame = frame_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      run_r     <= '0;
      low_run_r <= '0;
      bit_idx_r <= '0;
      frame_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      run_r     <= run_nxt;
      low_run_r <= low_run_nxt;
      bit_idx_r <= bit_idx_nxt;
      frame_r   <= frame_nxt;
    end
  end

  `SHWR_ASSERT_IMP(a_ev_ends_read, ev_push, phase_nxt == PH_IDLE, "event left read active")
  `SHWR_ASSERT_IMP(a_bit_idx_bound, 1'b1, bit_idx_r <= BW'(FB), "bit index past frame")

endmodule

`default_nettype wire

[hw/rtl/shwr_queue.sv]
// ----------------------------------------------------------------------------
// shwr_queue
// Small event queue between the line timer and the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module shwr_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire shwr_pkg::evt_t  push_data,
  input  wire logic            pop,
  output shwr_pkg::evt_t       head,
  output logic                 empty,
  output logic                 full
);

  `include "single_wire_humidity_sensor_receiver_macros.svh"

  localparam int DEPTH = shwr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  shwr_pkg::evt_t   data_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign empty   = cnt_r == '0;
  assign full    = cnt_r == CNT_W'(DEPTH);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = data_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  `SHWR_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH), "queue count overflow")

endmodule

`default_nettype wire

[hw/rtl/shwr_back.sv]
// ----------------------------------------------------------------------------
// shwr_back
// Result stage: checksum, stored reading, value formatting, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module shwr_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 sensor_mode,
  input  wire logic                                 read_temperature,
  input  wire shwr_pkg::evt_t                       head,
  input  wire logic                                 empty,
  output logic                                      pop,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      out_reading_ok,
  output logic        [shwr_pkg::STATUS_W-1:0]      out_status,
  output logic signed [shwr_pkg::VALUE_W-1:0]       out_value_tenths
);

  `include "single_wire_humidity_sensor_receiver_macros.svh"

  localparam int FB = shwr_pkg::FRAME_BITS;
  localparam int VW = shwr_pkg::VALUE_W;

  logic                   out_valid_r;
  logic                   ok_r,     ok_nxt;
  logic [shwr_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic signed [VW-1:0]   value_r,  value_nxt;
  logic                   last_ok_r, last_ok_nxt;
  logic [FB-1:0]          stored_r, stored_nxt;
  logic                   take;

  // Output register frees when empty or when its transfer completes
  assign take = !out_valid_r || !out_stall;
  assign pop  = take && !empty;

  // Turn one event into one result
  always_comb begin
    ok_nxt      = 1'b0;
    status_nxt  = shwr_pkg::ST_OK;
    value_nxt   = '0;
    last_ok_nxt = last_ok_r;
    stored_nxt  = stored_r;
    unique case (head.kind)
      shwr_pkg::EV_PRE_TO: begin
        // stale reading, validity kept
        ok_nxt     = last_ok_r;
        status_nxt = shwr_pkg::ST_PRE_TO;
        value_nxt  = last_ok_r ?
                     shwr_pkg::dht_value(stored_r, sensor_mode, read_temperature) : '0;
      end
      shwr_pkg::EV_BIT_TO: begin
        status_nxt  = shwr_pkg::ST_BIT_TO;
        last_ok_nxt = 1'b0;
      end
      shwr_pkg::EV_FRAME: begin
        if (shwr_pkg::csum_ok(head.frame)) begin
          ok_nxt      = 1'b1;
          status_nxt  = shwr_pkg::ST_OK;
          value_nxt   = shwr_pkg::dht_value(head.frame, sensor_mode, read_temperature);
          last_ok_nxt = 1'b1;
          stored_nxt  = head.frame;
        end else begin
          status_nxt  = shwr_pkg::ST_CSUM_ERR;
          last_ok_nxt = 1'b0;
        end
      end
      default: begin
        // unused kind code
      end
    endcase
  end

  // Reading state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ok_r <= 1'b0;
    end else if (pop) begin
      last_ok_r <= last_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r <= '0;
    end else if (pop) begin
      stored_r <= stored_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ok_r     <= ok_nxt;
      status_r <= status_nxt;
      value_r  <= value_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_reading_ok   = ok_r;
  assign out_status       = status_r;
  assign out_value_tenths = value_r;

  `SHWR_ASSERT_NXT(a_ok_only_by_frame, pop && (head.kind != shwr_pkg::EV_FRAME), !$rose(last_ok_r), "reading became valid without a frame")
  `SHWR_ASSERT_IMP(a_ok_status, out_valid_r && (status_r == shwr_pkg::ST_OK), ok_r, "ok status without valid reading")

endmodule

`default_nettype wire

[hw/rtl/single_wire_humidity_sensor_receiver.sv]
// Result path: the sample transfer that ends a read writes an event into the
// event queue, and the result register loads from the queue head once it is free.
// Throughput: 1 item per cycle; the input stalls only when the 4-entry event
// queue is full, which takes a held output stall.
// Reset: synchronous, active low; returns to idle with no valid reading and
// the register defaults (timeout 16000, DHT11, humidity).
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_receiver
// Single-wire humidity/temperature sensor receiver: line timer, event queue,
// result stage and configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module single_wire_humidity_sensor_receiver #(
  parameter int COUNTER_WIDTH = shwr_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration write port
  input  wire logic                                 cfg_we,
  input  wire logic        [shwr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [shwr_pkg::CFG_DATA_W-1:0] cfg_data,
  // sample channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_operation,
  input  wire logic                                 in_line_level,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      out_reading_ok,
  output logic        [shwr_pkg::STATUS_W-1:0]      out_status,
  output logic signed [shwr_pkg::VALUE_W-1:0]       out_value_tenths
);

  logic [shwr_pkg::TIMEOUT_W-1:0] timeout_r;
  logic                           mode_r;
  logic                           temp_sel_r;
  logic                           in_accept;
  logic                           ev_push;
  shwr_pkg::evt_t                 ev;
  shwr_pkg::evt_t                 head;
  logic                           q_empty;
  logic                           q_full;
  logic                           q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= shwr_pkg::TIMEOUT_RST;
      mode_r     <= 1'b0;
      temp_sel_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        shwr_pkg::CFG_TIMEOUT:   timeout_r  <= cfg_data[shwr_pkg::TIMEOUT_W-1:0];
        shwr_pkg::CFG_MODE:      mode_r     <= cfg_data[0];
        shwr_pkg::CFG_READ_TEMP: temp_sel_r <= cfg_data[0];
        default: begin
          // no register at this index
        end
      endcase
    end
  end

  // Input transfer
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  shwr_front #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .operation     (in_operation),
    .line_level    (in_line_level),
    .timeout_ticks (timeout_r),
    .ev_push       (ev_push),
    .ev            (ev)
  );

  shwr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ev_push),
    .push_data (ev),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  shwr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .sensor_mode      (mode_r),
    .read_temperature (temp_sel_r),
    .head             (head),
    .empty            (q_empty),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reading_ok   (out_reading_ok),
    .out_status       (out_status),
    .out_value_tenths (out_value_tenths)
  );

endmodule

`default_nettype wire

[tb/single_wire_humidity_sensor_receiver_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-wire humidity sensor receiver checker
// Watches the register port and both channels, predicts each reading from
// the sample transfers and compares every result transfer in order.
// ----------------------------------------------------------------------------

module single_wire_humidity_sensor_receiver_checker
  import shwr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_operation,
  input  logic                  in_line_level,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_reading_ok,
  input  logic [STATUS_W-1:0]   out_status,
  input  logic [VALUE_W-1:0]    out_value_tenths,
  output int                    mismatches,
  output int                    waiting,
  output int                    readings,
  output int                    ok_reads,
  output int                    pre_aborts,
  output int                    bit_aborts,
  output int                    sum_errors
);

  localparam int CW = COUNTER_WIDTH_DEF;

  typedef enum logic [2:0] {
    RX_IDLE,
    RX_PRE_LOW,
    RX_PRE_HIGH,
    RX_BIT_LOW,
    RX_BIT_HIGH
  } rx_phase_t;

  typedef struct packed {
    logic                ok;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
  } reading_t;

  // register copies
  logic [TIMEOUT_W-1:0] timeout_reg;
  logic                 mode_dht22;
  logic                 want_temp;

  // line timer copy
  rx_phase_t            rx_phase;
  logic [CW-1:0]        run_len;
  logic [CW-1:0]        low_len;
  logic [BIT_IDX_W-1:0] bits_in;
  logic [39:0]          shift_reg;
  logic [39:0]          kept_frame;
  logic                 kept_valid;

  reading_t reading_q[$];
  int       bad_count;
  int       seen_count;
  int       seen_status[4];

  // Tenths of a unit from the five frame bytes under the current mode
  function automatic logic [VALUE_W-1:0] tenths_of(input logic [39:0] f);
    logic [7:0]         hum_hi;
    logic [7:0]         hum_lo;
    logic [7:0]         tmp_hi;
    logic [7:0]         tmp_lo;
    logic [VALUE_W-1:0] mag;
    hum_hi = f[39:32];
    hum_lo = f[31:24];
    tmp_hi = f[23:16];
    tmp_lo = f[15:8];
    if (!mode_dht22) begin
      return want_temp ? VALUE_W'(tmp_hi) * VALUE_W'(10) : VALUE_W'(hum_hi) * VALUE_W'(10);
    end
    if (!want_temp) begin
      return {1'b0, hum_hi, hum_lo};
    end
    mag = {2'b00, tmp_hi[6:0], tmp_lo};
    return tmp_hi[7] ? -mag : mag;
  endfunction

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
    return (c == {CW{1'b1}}) ? c : c + 1'b1;
  endfunction

  // Queue one reading and end the read
  task automatic report(input logic [STATUS_W-1:0] st);
    reading_t r;
    r.ok     = kept_valid;
    r.status = st;
    r.value  = kept_valid ? tenths_of(kept_frame) : '0;
    reading_q.push_back(r);
    rx_phase = RX_IDLE;
  endtask

  task automatic abort_bit();
    kept_valid = 1'b0;
    report(ST_BIT_TO);
  endtask

  // Byte-sum check on a full frame
  task automatic frame_done();
    logic [7:0] sum;
    sum = shift_reg[39:32] + shift_reg[31:24] + shift_reg[23:16] + shift_reg[15:8];
    if (sum == shift_reg[7:0]) begin
      kept_frame = shift_reg;
      kept_valid = 1'b1;
      report(ST_OK);
    end else begin
      kept_valid = 1'b0;
      report(ST_CSUM_ERR);
    end
  endtask

  // One accepted input item
  task automatic take_sample(input logic start, input logic lvl);
    logic over;
    if (start) begin
      rx_phase  = RX_PRE_LOW;
      run_len   = '0;
      low_len   = '0;
      bits_in   = '0;
      shift_reg = '0;
      return;
    end
    case (rx_phase)
      RX_PRE_LOW: begin
        if (!lvl) run_len = bump(run_len);
        else begin
          rx_phase = RX_PRE_HIGH;
          run_len  = 1;
        end
        if (run_len > CW'(timeout_reg)) report(ST_PRE_TO);
      end
      RX_PRE_HIGH: begin
        if (lvl) begin
          run_len = bump(run_len);
          if (run_len > CW'(timeout_reg)) report(ST_PRE_TO);
        end else begin
          rx_phase = RX_BIT_LOW;
          run_len  = 1;
          if (run_len > CW'(timeout_reg)) abort_bit();
        end
      end
      RX_BIT_LOW: begin
        if (!lvl) run_len = bump(run_len);
        else begin
          low_len  = run_len;
          rx_phase = RX_BIT_HIGH;
          run_len  = 1;
        end
        if (run_len > CW'(timeout_reg)) abort_bit();
      end
      RX_BIT_HIGH: begin
        if (lvl) begin
          run_len = bump(run_len);
          if (run_len > CW'(timeout_reg)) abort_bit();
        end else begin
          // falling edge closes the bit: 1 when high lasted at least as long
          over      = (run_len >= low_len);
          shift_reg = {shift_reg[38:0], over};
          bits_in   = bits_in + 1'b1;
          if (bits_in >= FRAME_BITS) frame_done();
          else begin
            rx_phase = RX_BIT_LOW;
            run_len  = 1;
            if (run_len > CW'(timeout_reg)) abort_bit();
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic flag(input string note, input reading_t want);
    bad_count++;
    if (bad_count <= 10) begin
      $display("%0t checker: %s: expected ok=%0b status=%0d value=%0d, got ok=%0b status=%0d value=%0d",
               $time, note, want.ok, want.status, $signed(want.value),
               out_reading_ok, out_status, $signed(out_value_tenths));
    end
  endtask

  // One accepted result transfer against the oldest expected reading
  task automatic check_reading();
    reading_t want;
    seen_count++;
    case (out_status)
      ST_OK:       seen_status[0]++;
      ST_PRE_TO:   seen_status[1]++;
      ST_BIT_TO:   seen_status[2]++;
      ST_CSUM_ERR: seen_status[3]++;
      default: ;
    endcase
    if (reading_q.size() == 0) begin
      flag("result with no reading pending", '0);
      return;
    end
    want = reading_q.pop_front();
    if (out_reading_ok !== want.ok || out_status !== want.status ||
        out_value_tenths !== want.value) begin
      flag("reading mismatch", want);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      timeout_reg = TIMEOUT_RST;
      mode_dht22  = 1'b0;
      want_temp   = 1'b0;
      rx_phase    = RX_IDLE;
      run_len     = '0;
      low_len     = '0;
      bits_in     = '0;
      shift_reg   = '0;
      kept_frame  = '0;
      kept_valid  = 1'b0;
      reading_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT:   timeout_reg = cfg_data[TIMEOUT_W-1:0];
          CFG_MODE:      mode_dht22  = cfg_data[0];
          CFG_READ_TEMP: want_temp   = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_sample(in_operation, in_line_level);
      if (out_valid && !out_stall) check_reading();
    end
    mismatches <= bad_count;
    waiting    <= reading_q.size();
    readings   <= seen_count;
    ok_reads   <= seen_status[0];
    pre_aborts <= seen_status[1];
    bit_aborts <= seen_status[2];
    sum_errors <= seen_status[3];
  end

endmodule

[tb/single_wire_humidity_sensor_receiver_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-wire humidity sensor receiver test
// Drives sensor frames sample by sample (good frames, checksum errors,
// preamble and bit timeouts, restarts) over several register settings and
// idling patterns; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module single_wire_humidity_sensor_receiver_test;
  import shwr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int TOTAL_ITEMS    = 1750;
  localparam int MIN_SEGMENTS   = 4;
  localparam int RUN_CAP        = 3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_START  = 1'b1;

  typedef enum int {
    FAULT_NONE,
    FAULT_PRE_LOW,
    FAULT_PRE_HIGH,
    FAULT_BIT,
    FAULT_CUT
  } fault_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_operation;
  logic                  in_line_level;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_reading_ok;
  logic [STATUS_W-1:0]   out_status;
  logic [VALUE_W-1:0]    out_value_tenths;

  int mismatches;
  int waiting;
  int readings;
  int ok_reads;
  int pre_aborts;
  int bit_aborts;
  int sum_errors;

  int   tx_pct;
  int   rx_pct;
  int   timeout_now;
  int   items_sent;
  int   quiet;
  int   held_back;
  int   hold_left;
  logic hold_req;
  logic hold_done;

  single_wire_humidity_sensor_receiver u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_line_level    (in_line_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reading_ok   (out_reading_ok),
    .out_status       (out_status),
    .out_value_tenths (out_value_tenths)
  );

  single_wire_humidity_sensor_receiver_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_line_level    (in_line_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reading_ok   (out_reading_ok),
    .out_status       (out_status),
    .out_value_tenths (out_value_tenths),
    .mismatches       (mismatches),
    .waiting          (waiting),
    .readings         (readings),
    .ok_reads         (ok_reads),
    .pre_aborts       (pre_aborts),
    .bit_aborts       (bit_aborts),
    .sum_errors       (sum_errors)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stall, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_pct);
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (in_valid && in_stall) held_back <= held_back + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d readings pending", quiet, waiting);
      $display("single_wire_humidity_sensor_receiver_test: done, errors");
      $finish;
    end
  end

  // One input transfer, with a random gap ahead of it
  task automatic send_item(input logic op, input logic lvl);
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_line_level <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_run(input logic lvl, input int n);
    repeat (n) send_item(OP_SAMPLE, lvl);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Four random bytes and a checksum, correct or off by a nonzero amount
  function automatic logic [39:0] frame_bytes(input logic good);
    logic [31:0] body;
    logic [7:0]  sum;
    body = $urandom;
    sum  = body[31:24] + body[23:16] + body[15:8] + body[7:0];
    if (!good) sum = sum + 8'($urandom_range(1, 255));
    return {body, sum};
  endfunction

  // Start item, preamble, 40 low/high pairs and the closing falling edge;
  // a fault stretches one run past the timeout or abandons the frame
  task automatic send_read(input logic [39:0] bytes, input fault_t fault);
    int cap;
    int pre_lo;
    int pre_hi;
    int n;
    int m;
    int cut_at;
    cap = (timeout_now < RUN_CAP) ? timeout_now : RUN_CAP;
    send_item(OP_START, 1'($urandom_range(0, 1)));
    pre_lo = (fault == FAULT_PRE_LOW) ? timeout_now + 1 : $urandom_range(0, cap);
    send_run(1'b0, pre_lo);
    if (fault == FAULT_PRE_LOW) return;
    pre_hi = (fault == FAULT_PRE_HIGH) ? timeout_now + 1 : $urandom_range(1, cap);
    send_run(1'b1, pre_hi);
    if (fault == FAULT_PRE_HIGH) return;
    cut_at = $urandom_range(0, 79);
    for (int i = 0; i < 40; i++) begin
      if (bytes[39-i] || cap < 2) begin
        n = $urandom_range(1, cap);
        m = $urandom_range(n, cap);
      end else begin
        n = $urandom_range(2, cap);
        m = $urandom_range(1, n - 1);
      end
      if (fault == FAULT_BIT && cut_at == 2 * i) begin
        send_run(1'b0, timeout_now + 1);
        return;
      end
      send_run(1'b0, n);
      if (fault == FAULT_BIT && cut_at == 2 * i + 1) begin
        send_run(1'b1, timeout_now + 1);
        return;
      end
      if (fault == FAULT_CUT && cut_at == 2 * i + 1) return;
      send_run(1'b1, m);
    end
    send_item(OP_SAMPLE, 1'b0);
  endtask

  // Register writes only with the receiver idle and nothing pending
  task automatic write_config(input int ticks, input logic dht22, input logic temp);
    logic [31:0] pad;
    drop_valid();
    while (waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    pad = $urandom;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= CFG_DATA_W'(ticks);
    @(posedge clk);
    cfg_index <= CFG_MODE;
    cfg_data  <= {pad[CFG_DATA_W-2:0], dht22};
    @(posedge clk);
    pad = $urandom;
    cfg_index <= CFG_READ_TEMP;
    cfg_data  <= {pad[CFG_DATA_W-2:0], temp};
    @(posedge clk);
    cfg_we <= 1'b0;
    timeout_now = ticks;
  endtask

  task automatic set_idling(input int sel);
    case (sel)
      0: begin tx_pct = 0;  rx_pct <= 0;  end
      1: begin tx_pct = 58; rx_pct <= 0;  end
      2: begin tx_pct = 0;  rx_pct <= 58; end
      default: begin tx_pct = 24; rx_pct <= 24; end
    endcase
  endtask

  // One random read that always leaves the receiver idle: mostly well-formed,
  // the rest checksum errors, timeouts and an extra start ahead of the read
  task automatic random_read();
    int     pick;
    logic   good;
    fault_t fault;
    pick  = $urandom_range(0, 99);
    good  = 1'b1;
    fault = FAULT_NONE;
    if (pick < 50) good = 1'b1;
    else if (pick < 60) good = 1'b0;
    else if (pick < 70) fault = FAULT_PRE_LOW;
    else if (pick < 77) fault = FAULT_PRE_HIGH;
    else if (pick < 88) fault = FAULT_BIT;
    else send_item(OP_START, 1'($urandom_range(0, 1)));
    // long timeouts make over-length runs too costly
    if (timeout_now > 64) fault = FAULT_NONE;
    send_read(frame_bytes(good), fault);
    // samples while idle are ignored
    repeat ($urandom_range(0, 3)) send_item(OP_SAMPLE, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int base;
    int seg;
    int ticks;
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_TIMEOUT;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_operation  = OP_SAMPLE;
    in_line_level = 1'b0;
    out_stall     = 1'b0;
    tx_pct        = 0;
    rx_pct        = 0;
    timeout_now   = TIMEOUT_RST;
    items_sent    = 0;
    quiet         = 0;
    held_back     = 0;
    hold_left     = 0;
    hold_req      = 1'b0;
    hold_done     = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: samples straight after reset are ignored
    repeat (3) send_item(OP_SAMPLE, 1'($urandom_range(0, 1)));
    // preamble timeout with no stored reading yet
    write_config(6, 1'b0, 1'b0);
    send_read(frame_bytes(1'b1), FAULT_PRE_LOW);
    repeat (3) send_item(OP_SAMPLE, 1'($urandom_range(0, 1)));
    send_read(40'h00_00_00_00_00, FAULT_NONE);
    // stale stored reading on a preamble timeout
    send_read(frame_bytes(1'b1), FAULT_PRE_HIGH);
    // all-ones bytes: most negative temperature, then the same stored bytes
    // seen as largest humidity and DHT11 max through preamble timeouts
    write_config(6, 1'b1, 1'b1);
    send_read(40'hFF_FF_FF_FF_FC, FAULT_NONE);
    write_config(6, 1'b1, 1'b0);
    send_read(frame_bytes(1'b1), FAULT_PRE_LOW);
    write_config(6, 1'b0, 1'b1);
    send_read(frame_bytes(1'b1), FAULT_PRE_LOW);
    // bit timeout clears the reading, seen by the next preamble timeout
    send_read(frame_bytes(1'b1), FAULT_BIT);
    send_read(frame_bytes(1'b1), FAULT_PRE_LOW);
    // start during a read, a second start in a row, then a bad checksum
    send_read(frame_bytes(1'b1), FAULT_CUT);
    send_item(OP_START, 1'b1);
    send_read(frame_bytes(1'b0), FAULT_NONE);

    // Back-pressure: output held off while short aborted reads keep coming
    set_idling(0);
    write_config(1, 1'b1, 1'b0);
    hold_req <= 1'b1;
    repeat (30) send_read(frame_bytes(1'b1), FAULT_PRE_LOW);

    // Random segments over register settings and idling patterns
    base = items_sent;
    seg  = 0;
    while (seg < MIN_SEGMENTS || items_sent < TOTAL_ITEMS) begin
      set_idling(seg % 4);
      case (seg)
        0: write_config(8388607, 1'b0, 1'b0);
        1: write_config(1, 1'b1, 1'b1);
        2: write_config(5, 1'b1, 1'b0);
        3: write_config(3, 1'b0, 1'b1);
        default: begin
          ticks = ($urandom_range(0, 9) == 0) ? 16000 : $urandom_range(2, 12);
          write_config(ticks, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      endcase
      repeat (2) random_read();
      seg++;
    end

    drop_valid();
    while (waiting != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("summary: %0d items sent (%0d random) over %0d segments,",
             items_sent, items_sent - base, seg);
    $display("summary: input held back %0d cycles; %0d readings: %0d ok, %0d preamble",
             held_back, readings, ok_reads, pre_aborts);
    $display("summary: timeout, %0d bit timeout, %0d checksum",
             bit_aborts, sum_errors);
    if (mismatches == 0) begin
      $display("single_wire_humidity_sensor_receiver_test: done, clean");
    end else begin
      $display("single_wire_humidity_sensor_receiver_test: done, errors");
    end
    $finish;
  end

endmodule
